>>> src/vdac_pkg.sv
// Shared types and constants for the VGA DAC palette lookup unit.
`timescale 1ns / 1ps

package vdac_pkg;

  // Palette geometry
  localparam int PAL_DEPTH = 256;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam int COMP_W    = 6;
  localparam int BLUE_W    = COMP_W + 1;  // blue plus opaque flag on top
  localparam int DATA_W    = 8;
  localparam int WORD_W    = 32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Request action codes on the input channel
  localparam logic [1:0] ACT_SET_PTR = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;

  // Command codes carried through the queue
  localparam logic [1:0] OP_SET_PTR = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  // Component sequencer steps
  localparam logic [1:0] STEP_RED   = 2'd0;
  localparam logic [1:0] STEP_GREEN = 2'd1;
  localparam logic [1:0] STEP_BLUE  = 2'd2;
  localparam logic [1:0] STEP_BAD   = 2'd3;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [1:0] step;
    logic       rd_vld;
  } stat_t;

endpackage

>>> src/vdac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vdac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/vdac_front.sv
// Front end: accepts requests, classifies them and queues commands for the back end.
`timescale 1ns / 1ps

module vdac_front
  import vdac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [DATA_W-1:0] in_port_data,
  input  logic [IDX_W-1:0]  in_pixel_index,
  output logic              q_valid,
  input  logic              q_ready,
  output cmd_t              q_cmd
);

  cmd_t              q_mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  cmd_t cls_cmd;
  logic cls_keep;
  logic push, pop;

  // Classify: unused action code is accepted and dropped
  always_comb begin
    cls_cmd  = '0;
    cls_keep = 1'b1;
    case (in_action)
      ACT_SET_PTR: begin
        cls_cmd.op  = OP_SET_PTR;
        cls_cmd.arg = in_port_data;
      end
      ACT_WRITE: begin
        cls_cmd.op  = OP_WRITE;
        cls_cmd.arg = in_port_data;
      end
      ACT_LOOKUP: begin
        cls_cmd.op  = OP_LOOKUP;
        cls_cmd.arg = in_pixel_index;
      end
      default: begin
        cls_keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready && cls_keep;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

>>> src/vdac_back.sv
// Back end: component write sequencer, palette RAMs and lookup output stage.
`timescale 1ns / 1ps

module vdac_back
  import vdac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_rgba_word,
  output stat_t             stat
);

  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [PAL_DEPTH-1:0] ent_vld_r;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 rd_ok_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0]    out_word_r;

  logic pop, wr_pop, lk_pop, move, ent_ok;
  logic sel_r, sel_g, sel_b;
  logic we_r, we_g, we_b;
  logic [COMP_W-1:0] d6, wd_r, wd_g;
  logic [BLUE_W-1:0] wd_b;
  logic [COMP_W-1:0] rd_r, rd_g;
  logic [BLUE_W-1:0] rd_b;
  logic [7:0]        alpha;

  assign move    = rd_vld_r && (!out_vld_r || out_ready);
  assign q_ready = (q_cmd.op != OP_LOOKUP) || !rd_vld_r || move;
  assign pop     = q_valid && q_ready;
  assign wr_pop  = pop && (q_cmd.op == OP_WRITE);
  assign lk_pop  = pop && (q_cmd.op == OP_LOOKUP);
  assign d6      = q_cmd.arg[COMP_W-1:0];
  assign ent_ok  = ent_vld_r[ptr_r];

  always_comb begin
    sel_r = 1'b0;
    sel_g = 1'b0;
    sel_b = 1'b0;
    case (step_r)
      STEP_GREEN: sel_g = 1'b1;
      STEP_BLUE:  sel_b = 1'b1;
      default:    sel_r = 1'b1;  // red, also for the never-used step code
    endcase
  end

  // First write into a fresh entry zeroes the other components too
  assign we_r = wr_pop && (sel_r || !ent_ok);
  assign we_g = wr_pop && (sel_g || !ent_ok);
  assign we_b = wr_pop && (sel_b || !ent_ok);
  assign wd_r = sel_r ? d6 : '0;
  assign wd_g = sel_g ? d6 : '0;
  assign wd_b = sel_b ? {1'b1, d6} : {1'b0, rd_b[COMP_W-1:0] & '0};

  always_comb begin
    ptr_nxt  = ptr_r;
    step_nxt = step_r;
    if (pop && (q_cmd.op == OP_SET_PTR)) begin
      ptr_nxt  = q_cmd.arg[IDX_W-1:0];
      step_nxt = STEP_RED;
    end else if (wr_pop) begin
      if (sel_g) begin
        step_nxt = STEP_BLUE;
      end else if (sel_b) begin
        ptr_nxt  = ptr_r + 1'b1;
        step_nxt = STEP_RED;
      end else begin
        step_nxt = STEP_GREEN;
      end
    end
  end

  always_comb begin
    rd_vld_nxt = rd_vld_r;
    if (lk_pop) begin
      rd_vld_nxt = 1'b1;
    end else if (move) begin
      rd_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (move) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      step_r    <= STEP_RED;
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      step_r    <= step_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_pop) begin
        ent_vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  assign alpha = rd_b[BLUE_W-1] ? ALPHA_OPAQUE : ALPHA_CLEAR;

  always_ff @(posedge clk) begin
    if (lk_pop) begin
      rd_ok_r <= ent_vld_r[q_cmd.arg[IDX_W-1:0]];
    end
    if (move) begin
      out_word_r <= rd_ok_r ? {rd_r, 2'b00, rd_g, 2'b00, rd_b[COMP_W-1:0], 2'b00, alpha}
                            : '0;
    end
  end

  vdac_ram #(.WIDTH(COMP_W), .DEPTH(PAL_DEPTH)) u_ram_red (
    .clk   (clk),
    .we    (we_r),
    .waddr (ptr_r),
    .wdata (wd_r),
    .re    (lk_pop),
    .raddr (q_cmd.arg[IDX_W-1:0]),
    .rdata (rd_r)
  );

  vdac_ram #(.WIDTH(COMP_W), .DEPTH(PAL_DEPTH)) u_ram_green (
    .clk   (clk),
    .we    (we_g),
    .waddr (ptr_r),
    .wdata (wd_g),
    .re    (lk_pop),
    .raddr (q_cmd.arg[IDX_W-1:0]),
    .rdata (rd_g)
  );

  vdac_ram #(.WIDTH(BLUE_W), .DEPTH(PAL_DEPTH)) u_ram_blue (
    .clk   (clk),
    .we    (we_b),
    .waddr (ptr_r),
    .wdata (wd_b),
    .re    (lk_pop),
    .raddr (q_cmd.arg[IDX_W-1:0]),
    .rdata (rd_b)
  );

  assign out_valid     = out_vld_r;
  assign out_rgba_word = out_word_r;
  assign stat.step     = step_r;
  assign stat.rd_vld   = rd_vld_r;

endmodule

>>> src/vga_dac_palette_lookup_unit.sv
// Top level of the VGA DAC palette lookup unit.
// Throughput: one request per cycle sustained, lookups and writes alike, as
//   long as out_ready stays high. A lookup with nothing ahead passes the
//   command queue, the RAM read and the output register before out_valid rises.
// Reset (rst_n low, synchronous): pointer to entry 0, red next, queue and
//   output empty; per-entry valid flags all clear at reset, so no clearing pass.
`timescale 1ns / 1ps

module vga_dac_palette_lookup_unit
  import vdac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [DATA_W-1:0] in_port_data,
  input  logic [IDX_W-1:0]  in_pixel_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_rgba_word
);

  // Command queue handshake between front and back
  logic  q_valid;
  logic  q_ready;
  cmd_t  q_cmd;
  stat_t stat;

  // Front: takes every request; unused action codes are dropped here,
  // the rest are queued as commands (queue depth Q_DEPTH).
  vdac_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_port_data   (in_port_data),
    .in_pixel_index (in_pixel_index),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  // Back: runs the red/green/blue write sequencer against three palette
  // RAMs (blue RAM also holds the opaque flag) and serves lookups through
  // a RAM read stage and an output register. Writes never wait on the output
  // side; a lookup waits only while both stages are full and out_ready is low.
  vdac_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rgba_word (out_rgba_word),
    .stat          (stat)
  );

  // Sequencer never reaches the unused step code
  a_step_legal : assert property (@(posedge clk) disable iff (!rst_n)
    stat.step != STEP_BAD)
    else $error("component step reached unused code");

  // A lookup taken by the back end occupies the read stage next cycle
  a_lookup_issue : assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && (q_cmd.op == OP_LOOKUP) |=> stat.rd_vld)
    else $error("lookup lost between queue and read stage");

  // Lookup into an idle pipe goes through queue, read stage and output register
  a_lookup_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_LOOKUP) && !q_valid && !stat.rd_vld
      && !out_valid |-> ##3 out_valid)
    else $error("lookup did not reach output in time");

endmodule

>>> bench/vga_dac_palette_lookup_unit_test.sv
// Self-checking testbench for the VGA DAC palette lookup unit.
`timescale 1ns / 1ps

module vga_dac_palette_lookup_unit_test;
  import vdac_pkg::*;

  // Action code 3 has no meaning; the block must drop it silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RESET_CYCLES   = 9;
  localparam int DRAIN_CYCLES   = 12;    // extra wait once every expected word is seen
  localparam int STALL_LIMIT    = 5000;  // cycles with no handshake on either side
  localparam int ITEMS_PER_PASS = 325;   // four idle phases, ~1300 requests

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [DATA_W-1:0] in_port_data;
  logic [IDX_W-1:0]  in_pixel_index;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_rgba_word;

  vga_dac_palette_lookup_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_port_data   (in_port_data),
    .in_pixel_index (in_pixel_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rgba_word  (out_rgba_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow palette: 19-bit entries, {opaque, red[5:0], green[5:0], blue[5:0]},
  // plus the write pointer and the red/green/blue sequencer.
  // ---------------------------------------------------------------------------
  logic [18:0]       shadow_pal [PAL_DEPTH];
  logic [IDX_W-1:0]  shadow_wr_ptr;
  logic [1:0]        shadow_step;

  logic [WORD_W-1:0] rgba_expect_q [$];  // lookups accepted, word not yet seen
  int                err_cnt;
  int                send_idle_pct;      // chance the sender sits out a cycle
  int                recv_stall_pct;     // chance the receiver holds off a cycle

  // Advance the shadow palette by one accepted request. Returns 1 when the
  // request yields an output word (lookups only), with the word in rgba.
  function automatic bit palette_predict(input logic [1:0] act,
                                         input logic [DATA_W-1:0] data,
                                         input logic [IDX_W-1:0] pix,
                                         output logic [WORD_W-1:0] rgba);
    logic [18:0] ent;
    rgba = '0;
    case (act)
      ACT_SET_PTR: begin
        shadow_wr_ptr = data;
        shadow_step   = STEP_RED;
      end
      ACT_WRITE: begin
        ent = shadow_pal[shadow_wr_ptr];
        case (shadow_step)
          STEP_GREEN: begin
            ent[11:6] = data[5:0];
            shadow_pal[shadow_wr_ptr] = ent;
            shadow_step = STEP_BLUE;
          end
          STEP_BLUE: begin
            // blue completes the entry: opaque, pointer moves on (wraps)
            ent[5:0] = data[5:0];
            ent[18]  = 1'b1;
            shadow_pal[shadow_wr_ptr] = ent;
            shadow_wr_ptr = shadow_wr_ptr + 1'b1;
            shadow_step   = STEP_RED;
          end
          default: begin
            // red, and the never-expected fourth step value falls here too
            ent[17:12] = data[5:0];
            shadow_pal[shadow_wr_ptr] = ent;
            shadow_step = STEP_GREEN;
          end
        endcase
      end
      ACT_LOOKUP: begin
        ent  = shadow_pal[pix];
        rgba = {ent[17:12], 2'b00, ent[11:6], 2'b00, ent[5:0], 2'b00,
                ent[18] ? ALPHA_OPAQUE : ALPHA_CLEAR};
        return 1'b1;
      end
      default: ;  // unused code: no state change
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_cnt++;
  endtask

  // Drive one request at the falling edge, hold it until accepted, then
  // update the shadow palette. When pin is set, the expected word is the one
  // typed into the directed rows instead of the predicted one.
  // Returns at a falling edge with in_valid still high.
  task automatic send_request(input logic [1:0] act,
                              input logic [DATA_W-1:0] data,
                              input logic [IDX_W-1:0] pix,
                              input logic pin,
                              input logic [WORD_W-1:0] pinned_word);
    logic [WORD_W-1:0] rgba;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid       <= 1'b0;
      in_action      <= 2'($urandom);
      in_port_data   <= 8'($urandom);
      in_pixel_index <= 8'($urandom);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_port_data   <= data;
    in_pixel_index <= pix;
    do @(posedge clk); while (!in_ready);
    if (palette_predict(act, data, pix, rgba))
      rgba_expect_q.push_back(pin ? pinned_word : rgba);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: reset contents, extremes, partly written entries, pointer
  // wrap, step restart when the index is set again, and the unused action code.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]        act;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  pix;
    logic              pin;
    logic [WORD_W-1:0] word;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(input logic [1:0] act, input logic [DATA_W-1:0] data,
                         input logic [IDX_W-1:0] pix, input logic pin,
                         input logic [WORD_W-1:0] word);
    dir_row_t r;
    r.act  = act;
    r.data = data;
    r.pix  = pix;
    r.pin  = pin;
    r.word = word;
    dir_rows.push_back(r);
  endtask

  initial begin
    add_row(ACT_LOOKUP,  8'h00, 8'h00, 1'b1, 32'h0000_0000);  // cleared at reset
    add_row(ACT_LOOKUP,  8'hFF, 8'hFF, 1'b1, 32'h0000_0000);
    add_row(ACT_UNUSED,  8'hFF, 8'hFF, 1'b0, '0);             // dropped
    add_row(ACT_SET_PTR, 8'hFF, 8'h00, 1'b0, '0);             // top entry
    add_row(ACT_WRITE,   8'hFF, 8'h00, 1'b0, '0);             // red, top bits cut
    add_row(ACT_LOOKUP,  8'h00, 8'hFF, 1'b1, 32'hFC00_0000);  // partial, still clear
    add_row(ACT_WRITE,   8'h00, 8'hFF, 1'b0, '0);             // green
    add_row(ACT_WRITE,   8'hC0, 8'hFF, 1'b0, '0);             // blue -> 0, opaque
    add_row(ACT_LOOKUP,  8'h00, 8'hFF, 1'b1, 32'hFC00_00FF);
    add_row(ACT_WRITE,   8'h3F, 8'h00, 1'b0, '0);             // pointer wrapped to 0
    add_row(ACT_WRITE,   8'h3F, 8'h00, 1'b0, '0);
    add_row(ACT_WRITE,   8'h3F, 8'h00, 1'b0, '0);
    add_row(ACT_LOOKUP,  8'hFF, 8'h00, 1'b1, 32'hFCFC_FCFF);  // full white
    add_row(ACT_LOOKUP,  8'h00, 8'h01, 1'b1, 32'h0000_0000);  // never written
    add_row(ACT_SET_PTR, 8'h80, 8'h00, 1'b0, '0);
    add_row(ACT_WRITE,   8'h15, 8'h80, 1'b0, '0);             // red
    add_row(ACT_SET_PTR, 8'h80, 8'h00, 1'b0, '0);             // restart at red
    add_row(ACT_WRITE,   8'h2A, 8'h55, 1'b0, '0);             // red again
    add_row(ACT_LOOKUP,  8'h00, 8'h80, 1'b0, '0);
    add_row(ACT_WRITE,   8'h01, 8'hAA, 1'b0, '0);             // green
    add_row(ACT_WRITE,   8'h80, 8'h7F, 1'b0, '0);             // blue
    add_row(ACT_UNUSED,  8'h00, 8'h80, 1'b0, '0);
    add_row(ACT_LOOKUP,  8'h55, 8'h80, 1'b0, '0);
    add_row(ACT_LOOKUP,  8'h00, 8'h81, 1'b1, 32'h0000_0000);
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready is redrawn at every falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (recv_stall_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output check at the rising edge against the oldest pending lookup.
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (rgba_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h", out_rgba_word));
      end else begin
        want = rgba_expect_q.pop_front();
        if (out_rgba_word !== want)
          report_mismatch($sformatf("rgba_word %08h, want %08h", out_rgba_word, want));
      end
    end
  end

  // Watchdog: too long without a handshake on either channel means a hang.
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("vga_dac_palette_lookup_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random traffic: mostly a fresh index followed by whole red/green/blue
  // triples, with lookups of just-written and arbitrary entries in between;
  // the rest is lone writes, half-finished entries and unused codes.
  // ---------------------------------------------------------------------------
  task automatic random_pass(input int target);
    int sent;
    int pick;
    int triples;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_request(ACT_UNUSED, 8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 16) begin
        send_request(ACT_WRITE, 8'($urandom), 8'($urandom), 1'b0, '0);
        sent++;
      end else if (pick < 24) begin
        // broken entry: new index, then only red or red and green
        send_request(ACT_SET_PTR, 8'($urandom), 8'($urandom), 1'b0, '0);
        triples = $urandom_range(1, 2);
        for (int k = 0; k < triples; k++)
          send_request(ACT_WRITE, 8'($urandom), 8'($urandom), 1'b0, '0);
        send_request(ACT_LOOKUP, 8'($urandom), shadow_wr_ptr, 1'b0, '0);
        sent += triples + 2;
      end else if (pick < 40) begin
        send_request(ACT_LOOKUP, 8'($urandom), 8'($urandom), 1'b0, '0);
        sent++;
      end else begin
        send_request(ACT_SET_PTR, 8'($urandom), 8'($urandom), 1'b0, '0);
        sent++;
        triples = $urandom_range(1, 4);
        for (int t = 0; t < triples; t++) begin
          for (int k = 0; k < 3; k++)
            send_request(ACT_WRITE, 8'($urandom), 8'($urandom), 1'b0, '0);
          sent += 3;
          if ($urandom_range(1) == 1) begin
            send_request(ACT_LOOKUP, 8'($urandom), shadow_wr_ptr - 1'b1, 1'b0, '0);
            sent++;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_SET_PTR;
    in_port_data   = '0;
    in_pixel_index = '0;
    out_ready      = 1'b0;
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < PAL_DEPTH; i++)
      shadow_pal[i] = '0;
    shadow_wr_ptr = '0;
    shadow_step   = STEP_RED;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at full rate on both sides
    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].data, dir_rows[i].pix,
                   dir_rows[i].pin, dir_rows[i].word);

    // idle phases: none, sender only, receiver only, both
    random_pass(ITEMS_PER_PASS);
    send_idle_pct = 52;
    random_pass(ITEMS_PER_PASS);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    random_pass(ITEMS_PER_PASS);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    random_pass(ITEMS_PER_PASS);

    in_valid <= 1'b0;
    while (rgba_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("vga_dac_palette_lookup_unit test passed");
    end else begin
      $display("vga_dac_palette_lookup_unit test failed");
    end
    $finish;
  end

endmodule

>>> vga_dac_palette_lookup_unit.f
src/vdac_pkg.sv
src/vdac_ram.sv
src/vdac_front.sv
src/vdac_back.sv
src/vga_dac_palette_lookup_unit.sv
bench/vga_dac_palette_lookup_unit_test.sv
